FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the cluster peak finder RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cpf_pkg.sv
// Package for the cluster peak finder: payload structs, sequencer states,
// register indexes and fixed-point constants. No dependencies.
package cpf_pkg;

  localparam int unsigned MAX_BUCKETS_DEF = 64;

  localparam logic [15:0] MIN_THRESH          = 16'd3277;
  localparam logic [15:0] RESET_CLUSTER_FRAC  = 16'd29491;
  localparam logic [15:0] RESET_FORK_FRAC     = 16'd58982;

  localparam int unsigned POS_W  = 17;
  localparam int unsigned PROB_W = 16;

  typedef enum logic {
    CFG_CLUSTER_FRAC = 1'b0,
    CFG_FORK_FRAC    = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_THR,
    S_RD,
    S_CMP,
    S_ACC,
    S_DIV,
    S_FORK,
    S_DEC,
    S_OUT1
  } state_e;

  typedef struct packed {
    logic [15:0] probability;
    logic [16:0] edge_left;
    logic [16:0] edge_right;
    logic        last_bucket;
  } in_t;

  typedef struct packed {
    logic [16:0] peak_position;
    logic [15:0] peak_height;
    logic        primary_flag;
    logic        last_peak;
  } out_t;

endpackage

FILE: rtl/core/cpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/cpf_div.sv
// Restoring divider, one quotient bit per cycle, for the cluster centroid.
// The quotient must fit in QUO_W bits. No package dependency.
module cpf_div #(
  parameter int unsigned DIVISOR_W = 22,
  parameter int unsigned QUO_W     = 17
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DIVISOR_W+QUO_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]       divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [QUO_W-1:0]           quotient_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  always_comb begin
    trial  = {rem_q, quo_q[QUO_W-1]};
    diff   = trial - {1'b0, divisor_i};
    ge     = trial >= {1'b0, divisor_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W);
      rem_d  = dividend_i[DIVISOR_W+QUO_W-1:QUO_W];
      quo_d  = dividend_i[QUO_W-1:0];
    end else if (busy_q) begin
      rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/core/cluster_peak_finder.sv
// Cluster peak finder: stores a row of buckets, then finds up to two cluster peaks.
// Uses cpf_pkg, cpf_ram, cpf_div and assert_macros.svh.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_data_i) takes one bucket per
//   transfer. While a row is loading a bucket is taken every cycle; buckets
//   past MAX_BUCKETS are dropped, but a dropped last bucket still ends the row.
// - A bucket with last_bucket set starts the row evaluation; in_stall_o stays
//   high until the last result of the row sits in the output register.
// - Evaluating a row reads every stored bucket, weights each bucket inside a
//   cluster and runs the bit-serial centroid divider once per cluster; a second
//   result, held in a pending register, follows the first.
//   One 17x16 multiplier is shared by threshold, weighting and fork test.
// - Output channel (out_valid_o / out_stall_i / out_data_o) carries one or
//   two peaks, left to right, the final one flagged last_peak. A stalled result
//   holds in the output register; while the last one waits, a new row loads.
// - Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once.
// - Reset empties the row, clears the output valid flag and restores the
//   fraction registers; the bucket RAMs are not cleared.
`include "assert_macros.svh"

module cluster_peak_finder #(
  parameter int unsigned MAX_BUCKETS = cpf_pkg::MAX_BUCKETS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cpf_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cpf_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);
  import cpf_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_BUCKETS);
  localparam int unsigned CNT_W = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned TW_W  = PROB_W + AW;
  localparam int unsigned WX_W  = TW_W + POS_W;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  b_q, b_d;
  logic [15:0]       rpeak_q, rpeak_d;
  logic [AW-1:0]     fmax_q, fmax_d;
  logic [15:0]       cfrac_q, cfrac_d;
  logic [15:0]       ffrac_q, ffrac_d;
  logic              in_run_q, in_run_d;
  logic              have_best_q, have_best_d;
  logic              have_sec_q, have_sec_d;
  logic              out_valid_q, out_valid_d;

  logic [31:0]       thr_q, thr_d;
  logic [32:0]       mprod_q, mprod_d;
  logic [TW_W-1:0]   tw_q, tw_d;
  logic [WX_W-1:0]   wx_q, wx_d;
  logic [15:0]       pk_q, pk_d;
  logic [15:0]       best_pk_q, best_pk_d;
  logic [16:0]       best_pos_q, best_pos_d;
  logic [15:0]       sec_pk_q, sec_pk_d;
  logic [16:0]       sec_pos_q, sec_pos_d;
  out_t              out_q, out_d;
  out_t              pend_q, pend_d;

  logic              in_xfer;
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [16:0]       centre_in;
  logic [17:0]       edge_sum;
  logic [15:0]       prob_rd;
  logic [16:0]       centre_rd;
  logic [16:0]       mul_a;
  logic [15:0]       mul_b;
  logic [32:0]       mul_res;
  logic              above;
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [16:0]       div_quo;
  logic              out_free;
  logic              keep2;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign ram_we    = in_xfer && (cnt_q < CNT_W'(MAX_BUCKETS));
  assign edge_sum  = {1'b0, in_data_i.edge_left} + {1'b0, in_data_i.edge_right};
  assign centre_in = edge_sum[17:1];
  assign ram_raddr = (state_q == S_FORK || state_q == S_DEC) ? fmax_q : b_q[AW-1:0];

  cpf_ram #(.WIDTH(PROB_W), .DEPTH(MAX_BUCKETS)) u_prob_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (in_data_i.probability),
    .raddr_i (ram_raddr),
    .rdata_o (prob_rd)
  );

  cpf_ram #(.WIDTH(POS_W), .DEPTH(MAX_BUCKETS)) u_centre_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (centre_in),
    .raddr_i (ram_raddr),
    .rdata_o (centre_rd)
  );

  cpf_div #(.DIVISOR_W(TW_W), .QUO_W(POS_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wx_q),
    .divisor_i  (tw_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    case (state_q)
      S_THR: begin
        mul_a = {1'b0, rpeak_q};
        mul_b = cfrac_q;
      end
      S_FORK: begin
        mul_a = {1'b0, best_pk_q};
        mul_b = ffrac_q;
      end
      default: begin
        mul_a = centre_rd;
        mul_b = prob_rd;
      end
    endcase
    mul_res = 33'(mul_a) * 33'(mul_b);
  end

  assign above    = (b_q < n_q) && ({prob_rd, 16'h0000} >= thr_q) && (prob_rd >= MIN_THRESH);
  assign out_free = !out_valid_q || !out_stall_i;
  assign keep2    = have_sec_q && ({sec_pk_q, 16'h0000} >= thr_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    b_d         = b_q;
    rpeak_d     = rpeak_q;
    fmax_d      = fmax_q;
    cfrac_d     = cfrac_q;
    ffrac_d     = ffrac_q;
    in_run_d    = in_run_q;
    have_best_d = have_best_q;
    have_sec_d  = have_sec_q;
    thr_d       = thr_q;
    mprod_d     = mprod_q;
    tw_d        = tw_q;
    wx_d        = wx_q;
    pk_d        = pk_q;
    best_pk_d   = best_pk_q;
    best_pos_d  = best_pos_q;
    sec_pk_d    = sec_pk_q;
    sec_pos_d   = sec_pos_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CLUSTER_FRAC: cfrac_d = cfg_data_i;
        CFG_FORK_FRAC:    ffrac_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          if (ram_we) begin
            if (cnt_q == '0 || in_data_i.probability > rpeak_q) begin
              rpeak_d = in_data_i.probability;
              fmax_d  = cnt_q[AW-1:0];
            end
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (in_data_i.last_bucket) begin
            n_d     = ram_we ? cnt_q + CNT_W'(1) : cnt_q;
            state_d = S_THR;
          end
        end
      end
      S_THR: begin
        thr_d       = mul_res[31:0];
        b_d         = '0;
        in_run_d    = 1'b0;
        have_best_d = 1'b0;
        have_sec_d  = 1'b0;
        state_d     = S_RD;
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (above) begin
          tw_d     = (in_run_q ? tw_q : '0) + TW_W'(prob_rd);
          pk_d     = (!in_run_q || prob_rd > pk_q) ? prob_rd : pk_q;
          wx_d     = in_run_q ? wx_q : '0;
          mprod_d  = mul_res;
          in_run_d = 1'b1;
          state_d  = S_ACC;
        end else if (in_run_q) begin
          in_run_d  = 1'b0;
          div_start = 1'b1;
          state_d   = S_DIV;
        end else if (b_q == n_q) begin
          state_d = S_FORK;
        end else begin
          b_d     = b_q + CNT_W'(1);
          state_d = S_RD;
        end
      end
      S_ACC: begin
        wx_d    = wx_q + WX_W'(mprod_q);
        b_d     = b_q + CNT_W'(1);
        state_d = S_RD;
      end
      S_DIV: begin
        if (div_done) begin
          if (!have_best_q || pk_q > best_pk_q) begin
            if (have_best_q) begin
              sec_pk_d   = best_pk_q;
              sec_pos_d  = best_pos_q;
              have_sec_d = 1'b1;
            end
            best_pk_d   = pk_q;
            best_pos_d  = div_quo;
            have_best_d = 1'b1;
          end else if (!have_sec_q || pk_q > sec_pk_q) begin
            sec_pk_d   = pk_q;
            sec_pos_d  = div_quo;
            have_sec_d = 1'b1;
          end
          if (b_q == n_q) begin
            state_d = S_FORK;
          end else begin
            b_d     = b_q + CNT_W'(1);
            state_d = S_RD;
          end
        end
      end
      S_FORK: begin
        thr_d   = mul_res[31:0];
        state_d = S_DEC;
      end
      S_DEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          cnt_d       = '0;
          rpeak_d     = '0;
          fmax_d      = '0;
          state_d     = S_LOAD;
          if (!have_best_q) begin
            out_d = '{peak_position: centre_rd, peak_height: rpeak_q,
                      primary_flag: 1'b1, last_peak: 1'b1};
          end else if (!keep2) begin
            out_d = '{peak_position: best_pos_q, peak_height: best_pk_q,
                      primary_flag: 1'b1, last_peak: 1'b1};
          end else if (sec_pos_q < best_pos_q) begin
            out_d  = '{peak_position: sec_pos_q, peak_height: sec_pk_q,
                       primary_flag: 1'b0, last_peak: 1'b0};
            pend_d = '{peak_position: best_pos_q, peak_height: best_pk_q,
                       primary_flag: 1'b1, last_peak: 1'b1};
            state_d = S_OUT1;
          end else begin
            out_d  = '{peak_position: best_pos_q, peak_height: best_pk_q,
                       primary_flag: 1'b1, last_peak: 1'b0};
            pend_d = '{peak_position: sec_pos_q, peak_height: sec_pk_q,
                       primary_flag: 1'b0, last_peak: 1'b1};
            state_d = S_OUT1;
          end
        end
      end
      S_OUT1: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      n_q         <= '0;
      b_q         <= '0;
      rpeak_q     <= '0;
      fmax_q      <= '0;
      cfrac_q     <= RESET_CLUSTER_FRAC;
      ffrac_q     <= RESET_FORK_FRAC;
      in_run_q    <= 1'b0;
      have_best_q <= 1'b0;
      have_sec_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      b_q         <= b_d;
      rpeak_q     <= rpeak_d;
      fmax_q      <= fmax_d;
      cfrac_q     <= cfrac_d;
      ffrac_q     <= ffrac_d;
      in_run_q    <= in_run_d;
      have_best_q <= have_best_d;
      have_sec_q  <= have_sec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q      <= thr_d;
    mprod_q    <= mprod_d;
    tw_q       <= tw_d;
    wx_q       <= wx_d;
    pk_q       <= pk_d;
    best_pk_q  <= best_pk_d;
    best_pos_q <= best_pos_d;
    sec_pk_q   <= sec_pk_d;
    sec_pos_q  <= sec_pos_d;
    out_q      <= out_d;
    pend_q     <= pend_d;
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CPF_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_BUCKETS), "bucket count overflow")
  `CPF_ASSERT_IMP(a_sec_needs_best, have_sec_q, have_best_q, "second cluster without primary")
  `CPF_ASSERT_IMP(a_div_in_state, div_busy || div_done, state_q == S_DIV, "divider runs outside DIV")
  `CPF_ASSERT_NXT(a_last_starts, in_xfer && in_data_i.last_bucket, state_q == S_THR, "row end missed")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for cluster_peak_finder: sends rows of buckets, predicts the one or two
// cluster peaks of each row and checks every output transfer against them.
// Depends on cpf_pkg and the cluster_peak_finder RTL.
module testbench;
  import cpf_pkg::*;

  localparam int BUCKET_DEPTH  = MAX_BUCKETS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 3 * BUCKET_DEPTH + 19 * (BUCKET_DEPTH / 2) + 16;
  localparam int HOLD_CYCLES   = 600;
  localparam int LIMIT_CYCLES  = 600000;

  typedef enum int {ROW_CLUSTERED, ROW_FAINT, ROW_NOISE} row_style_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  // predictor state
  logic [15:0] prob_mem [BUCKET_DEPTH];
  logic [16:0] centre_mem [BUCKET_DEPTH];
  int          row_len;
  logic [15:0] row_peak;
  int          first_max;
  logic [15:0] cluster_frac;
  logic [15:0] fork_frac;

  out_t        expected_peaks [$];
  int          errors;
  int          hold_request;
  bit          steady_traffic;

  always #5 clk_i = ~clk_i;

  cluster_peak_finder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic void push_peak(input logic [16:0] pos, input logic [15:0] conf,
                                    input logic prim, input logic fin);
    out_t r;
    r.peak_position = pos;
    r.peak_height   = conf;
    r.primary_flag  = prim;
    r.last_peak     = fin;
    expected_peaks.insert(expected_peaks.size(), r);
  endfunction

  function automatic void find_row_peaks();
    longint unsigned thr_prod, tw, wx;
    logic [15:0]     run_pk, best_pk, sec_pk;
    logic [16:0]     run_pos, best_pos, sec_pos;
    bit              have_best, have_sec, in_run, above;
    int              b;
    thr_prod  = 64'(row_peak) * 64'(cluster_frac);
    have_best = 1'b0;
    have_sec  = 1'b0;
    in_run    = 1'b0;
    tw = 0; wx = 0; run_pk = '0;
    best_pk = '0; best_pos = '0; sec_pk = '0; sec_pos = '0;
    for (b = 0; b <= row_len; b++) begin
      above = 1'b0;
      if (b < row_len)
        above = (64'({prob_mem[b], 16'h0000}) >= thr_prod) && (prob_mem[b] >= MIN_THRESH);
      if (above) begin
        if (!in_run) begin
          in_run = 1'b1;
          tw = 0;
          wx = 0;
          run_pk = '0;
        end
        if (prob_mem[b] > run_pk) run_pk = prob_mem[b];
        tw += 64'(prob_mem[b]);
        wx += 64'(centre_mem[b]) * 64'(prob_mem[b]);
      end else if (in_run) begin
        in_run  = 1'b0;
        run_pos = 17'(wx / tw);
        if (!have_best || run_pk > best_pk) begin
          if (have_best) begin
            sec_pk   = best_pk;
            sec_pos  = best_pos;
            have_sec = 1'b1;
          end
          best_pk   = run_pk;
          best_pos  = run_pos;
          have_best = 1'b1;
        end else if (!have_sec || run_pk > sec_pk) begin
          sec_pk   = run_pk;
          sec_pos  = run_pos;
          have_sec = 1'b1;
        end
      end
    end
    if (!have_best) begin
      push_peak(centre_mem[first_max], row_peak, 1'b1, 1'b1);
    end else if (have_sec &&
                 64'({sec_pk, 16'h0000}) >= 64'(best_pk) * 64'(fork_frac)) begin
      if (sec_pos < best_pos) begin
        push_peak(sec_pos, sec_pk, 1'b0, 1'b0);
        push_peak(best_pos, best_pk, 1'b1, 1'b1);
      end else begin
        push_peak(best_pos, best_pk, 1'b1, 1'b0);
        push_peak(sec_pos, sec_pk, 1'b0, 1'b1);
      end
    end else begin
      push_peak(best_pos, best_pk, 1'b1, 1'b1);
    end
  endfunction

  function automatic void store_bucket(input in_t b);
    if (row_len < BUCKET_DEPTH) begin
      prob_mem[row_len]   = b.probability;
      centre_mem[row_len] = 17'((18'(b.edge_left) + 18'(b.edge_right)) >> 1);
      if (row_len == 0 || b.probability > row_peak) begin
        row_peak  = b.probability;
        first_max = row_len;
      end
      row_len++;
    end
    if (b.last_bucket) begin
      find_row_peaks();
      row_len   = 0;
      row_peak  = '0;
      first_max = 0;
    end
  endfunction

  function automatic in_t mk_bucket(input int p, input int l, input int r, input bit fin);
    in_t b;
    b.probability = 16'(p);
    b.edge_left   = 17'(l);
    b.edge_right  = 17'(r);
    b.last_bucket = fin;
    return b;
  endfunction

  task automatic send_bucket(input in_t b);
    if (!steady_traffic && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_data_i  <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    store_bucket(b);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_peaks.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    wait_idle();
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CLUSTER_FRAC) cluster_frac = value;
    else fork_frac = value;
  endtask

  task automatic send_row(input int len, input row_style_e style);
    int  i, w, level;
    in_t b;
    w     = 65536 / len;
    level = $urandom_range(MIN_THRESH, 65535);
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2:       b.probability = 16'($urandom_range(0, MIN_THRESH - 1));
        3, 4, 5, 6, 7: b.probability = 16'(level - $urandom_range(0, level / 4));
        8:             b.probability = 16'(level);
        default:       b.probability = 16'($urandom);
      endcase
      if (style == ROW_NOISE) b.probability = 16'($urandom);
      else if (style == ROW_FAINT) b.probability = 16'($urandom_range(3200, MIN_THRESH - 1));
      if (style == ROW_NOISE || $urandom_range(0, 7) == 0) begin
        b.edge_left  = 17'($urandom_range(0, 65536));
        b.edge_right = 17'($urandom_range(0, 65536));
      end else begin
        b.edge_left  = 17'(i * w);
        b.edge_right = (i == len - 1) ? 17'd65536 : 17'((i + 1) * w);
      end
      b.last_bucket = (i == len - 1) || (style == ROW_NOISE && $urandom_range(0, 5) == 0);
      send_bucket(b);
    end
  endtask

  task automatic run_random_rows(input int n_items);
    int         sent, len, roll;
    row_style_e style;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) len = $urandom_range(1, 12);
      else if (roll < 94) len = $urandom_range(13, 40);
      else if (roll < 98) len = $urandom_range(41, BUCKET_DEPTH);
      else len = $urandom_range(BUCKET_DEPTH + 1, BUCKET_DEPTH + 8);
      roll = $urandom_range(0, 19);
      style = (roll == 0) ? ROW_NOISE : (roll <= 2) ? ROW_FAINT : ROW_CLUSTERED;
      send_row(len, style);
      sent += len;
    end
  endtask

  task automatic test_corner_rows();
    send_bucket(mk_bucket(0, 0, 0, 1'b1));
    send_bucket(mk_bucket(65535, 65536, 65536, 1'b1));
    send_bucket(mk_bucket(MIN_THRESH - 1, 0, 65536, 1'b1));
    send_bucket(mk_bucket(MIN_THRESH, 1, 2, 1'b1));
    // equal peaks at the same position
    send_bucket(mk_bucket(40000, 1000, 1000, 1'b0));
    send_bucket(mk_bucket(0, 1000, 2000, 1'b0));
    send_bucket(mk_bucket(40000, 1000, 1000, 1'b1));
    // secondary left of primary
    send_bucket(mk_bucket(60000, 0, 200, 1'b0));
    send_bucket(mk_bucket(100, 200, 400, 1'b0));
    send_bucket(mk_bucket(65535, 60000, 65536, 1'b1));
    // secondary below fork fraction
    send_bucket(mk_bucket(50000, 0, 100, 1'b0));
    send_bucket(mk_bucket(0, 100, 200, 1'b0));
    send_bucket(mk_bucket(65535, 131071, 131071, 1'b1));
    // three clusters, one multi-bucket
    send_bucket(mk_bucket(30000, 0, 1000, 1'b0));
    send_bucket(mk_bucket(0, 1000, 2000, 1'b0));
    send_bucket(mk_bucket(65535, 2000, 3000, 1'b0));
    send_bucket(mk_bucket(50000, 3000, 4000, 1'b0));
    send_bucket(mk_bucket(0, 4000, 5000, 1'b0));
    send_bucket(mk_bucket(62000, 5000, 65535, 1'b1));
  endtask

  task automatic test_long_rows();
    send_row(BUCKET_DEPTH, ROW_CLUSTERED);
    send_row(BUCKET_DEPTH + 6, ROW_CLUSTERED);
  endtask

  task automatic test_fraction_settings();
    write_reg(CFG_CLUSTER_FRAC, 16'h0000);
    write_reg(CFG_FORK_FRAC, 16'hFFFF);
    run_random_rows(65);
    write_reg(CFG_CLUSTER_FRAC, 16'hFFFF);
    write_reg(CFG_FORK_FRAC, 16'h0000);
    run_random_rows(65);
    write_reg(CFG_CLUSTER_FRAC, 16'($urandom));
    write_reg(CFG_FORK_FRAC, 16'($urandom));
    run_random_rows(65);
  endtask

  task automatic test_output_holdoff();
    wait_idle();
    hold_request = HOLD_CYCLES;
    run_random_rows(40);
  endtask

  task automatic test_steady_traffic();
    write_reg(CFG_CLUSTER_FRAC, RESET_CLUSTER_FRAC);
    write_reg(CFG_FORK_FRAC, RESET_FORK_FRAC);
    run_random_rows(65);
    wait_idle();
    steady_traffic = 1'b1;
    run_random_rows(65);
  endtask

  initial begin : receiver
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!steady_traffic && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_peaks
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_peaks.size() == 0) begin
        errors++;
        $display("%0t: peak transfer expected none, actual %p", $time, out_data_o);
      end else begin
        want = expected_peaks.pop_front();
        if (want.peak_position !== out_data_o.peak_position) begin
          errors++;
          $display("%0t: peak_position expected %0d, actual %0d", $time,
                   want.peak_position, out_data_o.peak_position);
        end
        if (want.peak_height !== out_data_o.peak_height) begin
          errors++;
          $display("%0t: peak_height expected %0d, actual %0d", $time,
                   want.peak_height, out_data_o.peak_height);
        end
        if (want.primary_flag !== out_data_o.primary_flag) begin
          errors++;
          $display("%0t: primary_flag expected %0b, actual %0b", $time,
                   want.primary_flag, out_data_o.primary_flag);
        end
        if (want.last_peak !== out_data_o.last_peak) begin
          errors++;
          $display("%0t: last_peak expected %0b, actual %0b", $time,
                   want.last_peak, out_data_o.last_peak);
        end
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = 1'b0;
    cfg_data_i     = '0;
    row_len        = 0;
    row_peak       = '0;
    first_max      = 0;
    cluster_frac   = RESET_CLUSTER_FRAC;
    fork_frac      = RESET_FORK_FRAC;
    errors         = 0;
    hold_request   = 0;
    steady_traffic = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_corner_rows();
    test_long_rows();
    test_output_holdoff();
    test_fraction_settings();
    test_steady_traffic();

    in_valid_i <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
